// ===== rtl/pda_pkg.sv =====
// Package: shared types, codes and constants for the pushdown automaton recognizer.
`timescale 1ns / 1ps
package pda_pkg;

    localparam int TableDepthDefault = 64;
    localparam int StackDepthDefault = 256;
    localparam int StateCount        = 16;

    localparam logic [3:0] StartStateReset   = 4'd0;
    localparam logic [7:0] InitSymbolReset   = 8'd90;
    localparam logic [9:0] EpsLimitReset     = 10'd256;

    // operation codes
    localparam logic [2:0] OpLoad  = 3'd0;
    localparam logic [2:0] OpStart = 3'd1;
    localparam logic [2:0] OpPush  = 3'd2;
    localparam logic [2:0] OpSym   = 3'd3;
    localparam logic [2:0] OpEnd   = 3'd4;

    // status codes
    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StStuck    = 2'd1;
    localparam logic [1:0] StOverflow = 2'd2;
    localparam logic [1:0] StEps      = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CfgStartState = 3'd0;
    localparam logic [2:0] CfgInitSymbol = 3'd1;
    localparam logic [2:0] CfgAcceptMask = 3'd2;
    localparam logic [2:0] CfgAcceptEmpty = 3'd3;
    localparam logic [2:0] CfgEntryCount = 3'd4;
    localparam logic [2:0] CfgEpsLimit   = 3'd5;

    typedef struct packed {
        logic [3:0] st;
        logic       eps;
        logic [7:0] sym;
        logic [7:0] top;
        logic [3:0] nxt;
        logic [1:0] cnt;
        logic [7:0] p1;
        logic [7:0] p2;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TOP_RD,
        S_TOP_CAP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_APPLY,
        S_PUSH2,
        S_NEXT,
        S_NOMATCH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       load_entry;
        logic       start_run;
        logic       push_sym;
        logic       halt;
        logic       finish;
        logic [1:0] status;
        logic       acc_eval;
        logic       eps_clear;
        logic       top_read;
        logic       idx_clear;
        logic       tbl_read;
        logic       idx_inc;
        logic       apply;
        logic       push_second;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       halted;
        logic       sp_zero;
        logic       sp_full;
        logic       scan_done;
        logic       match;
        logic       ent_eps;
        logic       eps_over;
        logic       ovf;
        logic       cnt_two;
    } t_stat;

endpackage

// ===== rtl/pda_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module pda_ram #(
    parameter int W = 8,
    parameter int D = 256,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/pda_ctrl.sv =====
// Sequencer for the pushdown automaton recognizer.
`timescale 1ns / 1ps
module pda_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pda_pkg::t_stat i_stat,
    output pda_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    pda_pkg::t_state r_state, n_state;
    logic            op_walk;

    assign op_walk = (i_stat.op == pda_pkg::OpSym) || (i_stat.op == pda_pkg::OpEnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pda_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pda_pkg::S_IDLE: begin
                if (i_start) n_state = pda_pkg::S_DECODE;
            end
            pda_pkg::S_DECODE: begin
                if (op_walk && !i_stat.halted) n_state = pda_pkg::S_TOP_RD;
                else n_state = pda_pkg::S_IDLE;
            end
            pda_pkg::S_TOP_RD: begin
                n_state = i_stat.sp_zero ? pda_pkg::S_NOMATCH : pda_pkg::S_TOP_CAP;
            end
            pda_pkg::S_TOP_CAP: n_state = pda_pkg::S_SCAN_RD;
            pda_pkg::S_SCAN_RD: begin
                n_state = i_stat.scan_done ? pda_pkg::S_NOMATCH : pda_pkg::S_SCAN_CMP;
            end
            pda_pkg::S_SCAN_CMP: begin
                n_state = i_stat.match ? pda_pkg::S_APPLY : pda_pkg::S_SCAN_RD;
            end
            pda_pkg::S_APPLY: begin
                if ((i_stat.ent_eps && i_stat.eps_over) || i_stat.ovf) n_state = pda_pkg::S_IDLE;
                else if (i_stat.cnt_two) n_state = pda_pkg::S_PUSH2;
                else n_state = pda_pkg::S_NEXT;
            end
            pda_pkg::S_PUSH2: n_state = pda_pkg::S_NEXT;
            pda_pkg::S_NEXT: begin
                n_state = i_stat.ent_eps ? pda_pkg::S_TOP_RD : pda_pkg::S_IDLE;
            end
            pda_pkg::S_NOMATCH: n_state = pda_pkg::S_IDLE;
            default: n_state = pda_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.status = pda_pkg::StOk;
        case (r_state)
            pda_pkg::S_IDLE: begin
                o_cmd.capture = i_start;
            end
            pda_pkg::S_DECODE: begin
                if (i_stat.op == pda_pkg::OpLoad) begin
                    o_cmd.load_entry = 1'b1;
                    o_cmd.finish     = 1'b1;
                end else if (i_stat.op == pda_pkg::OpStart) begin
                    o_cmd.start_run = 1'b1;
                    o_cmd.finish    = 1'b1;
                end else if ((i_stat.op == pda_pkg::OpPush) || op_walk) begin
                    if (i_stat.halted) begin
                        o_cmd.status = pda_pkg::StStuck;
                        o_cmd.finish = 1'b1;
                    end else if (i_stat.op == pda_pkg::OpPush) begin
                        o_cmd.finish = 1'b1;
                        if (i_stat.sp_full) begin
                            o_cmd.status = pda_pkg::StOverflow;
                            o_cmd.halt   = 1'b1;
                        end else begin
                            o_cmd.push_sym = 1'b1;
                        end
                    end else begin
                        o_cmd.eps_clear = 1'b1;
                    end
                end else begin
                    o_cmd.finish = 1'b1;
                end
            end
            pda_pkg::S_TOP_RD: begin
                o_cmd.top_read  = 1'b1;
                o_cmd.idx_clear = 1'b1;
            end
            pda_pkg::S_SCAN_RD: begin
                o_cmd.tbl_read = !i_stat.scan_done;
            end
            pda_pkg::S_SCAN_CMP: begin
                o_cmd.idx_inc = !i_stat.match;
            end
            pda_pkg::S_APPLY: begin
                if (i_stat.ent_eps && i_stat.eps_over) begin
                    o_cmd.status = pda_pkg::StEps;
                    o_cmd.halt   = 1'b1;
                    o_cmd.finish = 1'b1;
                end else if (i_stat.ovf) begin
                    o_cmd.status = pda_pkg::StOverflow;
                    o_cmd.halt   = 1'b1;
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.apply = 1'b1;
                end
            end
            pda_pkg::S_PUSH2: o_cmd.push_second = 1'b1;
            pda_pkg::S_NEXT: begin
                o_cmd.finish = !i_stat.ent_eps;
            end
            pda_pkg::S_NOMATCH: begin
                o_cmd.finish = 1'b1;
                if (i_stat.op == pda_pkg::OpEnd) begin
                    o_cmd.acc_eval = 1'b1;
                end else begin
                    o_cmd.status = pda_pkg::StStuck;
                    o_cmd.halt   = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != pda_pkg::S_IDLE);
endmodule

// ===== rtl/pda_dp.sv =====
// Datapath: configuration, run state, transition table and symbol stack.
`timescale 1ns / 1ps
module pda_dp #(
    parameter int TABLE_DEPTH = pda_pkg::TableDepthDefault,
    parameter int STACK_DEPTH = pda_pkg::StackDepthDefault,
    localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int TCW = $clog2(TABLE_DEPTH + 1),
    localparam int SAW = $clog2(STACK_DEPTH),
    localparam int SPW = $clog2(STACK_DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pda_pkg::t_cmd  i_cmd,
    output pda_pkg::t_stat o_stat,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic [2:0]     i_op,
    input  logic [5:0]     i_entry_index,
    input  pda_pkg::t_entry i_entry,
    input  logic [7:0]     i_symbol,
    output logic           o_done,
    output logic [1:0]     o_status,
    output logic           o_accepted,
    output logic [3:0]     o_current_state,
    output logic [SPW-1:0] o_stack_level
);
    // configuration
    logic [3:0]  r_start_state;
    logic [7:0]  r_init_sym;
    logic [15:0] r_accept_mask;
    logic        r_accept_empty;
    logic [6:0]  r_entry_count;
    logic [9:0]  r_eps_limit;

    // latched word
    logic [2:0]      r_op;
    logic [5:0]      r_idx_in;
    pda_pkg::t_entry r_ent_in;
    logic [7:0]      r_sym;

    // run state
    logic [SPW-1:0] r_sp;
    logic [3:0]     r_st;
    logic           r_halted;
    logic [9:0]     r_eps_cnt;
    logic [TCW-1:0] r_idx;
    logic [7:0]     r_top;
    logic           r_top_cap;
    logic           r_done;
    logic [1:0]     r_status;
    logic           r_acc;

    pda_pkg::t_entry ent;
    logic [$bits(pda_pkg::t_entry)-1:0] tbl_rdata;
    logic [7:0]     stk_rdata;
    logic [SPW-1:0] base;
    logic [1:0]     cnt_eff;
    logic [31:0]    push_end;
    logic [31:0]    idx_load;
    logic [31:0]    scan_pos;
    logic [TAW-1:0] tbl_waddr;
    logic           tbl_we;
    logic           stk_we;
    logic [SPW-1:0] stk_wptr;
    logic [7:0]     stk_wdata;
    logic           acc_val;

    assign ent      = pda_pkg::t_entry'(tbl_rdata);
    assign base     = r_sp - SPW'(1);
    assign cnt_eff  = (ent.cnt == 2'd3) ? 2'd2 : ent.cnt;
    assign push_end = {{(32-SPW){1'b0}}, base} + {30'd0, cnt_eff};
    assign idx_load = {26'd0, r_idx_in};
    assign scan_pos = {{(32-TCW){1'b0}}, r_idx};
    assign tbl_waddr = idx_load[TAW-1:0];
    assign tbl_we   = i_cmd.load_entry && (idx_load < TABLE_DEPTH);

    always_comb begin
        stk_we    = 1'b0;
        stk_wptr  = r_sp;
        stk_wdata = r_sym;
        if (i_cmd.start_run) begin
            stk_we    = 1'b1;
            stk_wptr  = '0;
            stk_wdata = r_init_sym;
        end else if (i_cmd.push_sym) begin
            stk_we = 1'b1;
        end else if (i_cmd.apply) begin
            stk_we    = (cnt_eff != 2'd0);
            stk_wptr  = base;
            stk_wdata = (cnt_eff == 2'd2) ? ent.p2 : ent.p1;
        end else if (i_cmd.push_second) begin
            stk_we    = 1'b1;
            stk_wdata = ent.p1;
        end
    end

    pda_ram #(.W($bits(pda_pkg::t_entry)), .D(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (r_ent_in),
        .i_re    (i_cmd.tbl_read),
        .i_raddr (r_idx[TAW-1:0]),
        .o_rdata (tbl_rdata)
    );

    pda_ram #(.W(8), .D(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_wptr[SAW-1:0]),
        .i_wdata (stk_wdata),
        .i_re    (i_cmd.top_read),
        .i_raddr (base[SAW-1:0]),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        if (r_accept_empty) acc_val = (r_sp == '0);
        else acc_val = ({28'd0, r_st} < pda_pkg::StateCount) && r_accept_mask[r_st];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state  <= pda_pkg::StartStateReset;
            r_init_sym     <= pda_pkg::InitSymbolReset;
            r_accept_mask  <= '0;
            r_accept_empty <= 1'b0;
            r_entry_count  <= '0;
            r_eps_limit    <= pda_pkg::EpsLimitReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pda_pkg::CfgStartState:  r_start_state  <= i_cfg_data[3:0];
                pda_pkg::CfgInitSymbol:  r_init_sym     <= i_cfg_data[7:0];
                pda_pkg::CfgAcceptMask:  r_accept_mask  <= i_cfg_data;
                pda_pkg::CfgAcceptEmpty: r_accept_empty <= i_cfg_data[0];
                pda_pkg::CfgEntryCount:  r_entry_count  <= i_cfg_data[6:0];
                pda_pkg::CfgEpsLimit:    r_eps_limit    <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // input word latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_idx_in <= i_entry_index;
            r_ent_in <= i_entry;
            r_sym    <= i_symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_cap <= i_cmd.top_read;
        if (r_top_cap) r_top <= stk_rdata;
    end

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_st      <= '0;
            r_halted  <= 1'b0;
            r_eps_cnt <= '0;
            r_idx     <= '0;
            r_done    <= 1'b0;
            r_status  <= pda_pkg::StOk;
            r_acc     <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_status <= i_cmd.status;
                r_acc    <= i_cmd.acc_eval && acc_val;
            end
            if (i_cmd.halt) r_halted <= 1'b1;
            if (i_cmd.start_run) begin
                r_st     <= r_start_state;
                r_sp     <= SPW'(1);
                r_halted <= 1'b0;
            end
            if (i_cmd.push_sym) r_sp <= r_sp + SPW'(1);
            if (i_cmd.eps_clear) r_eps_cnt <= '0;
            if (i_cmd.idx_clear) r_idx <= '0;
            else if (i_cmd.idx_inc) r_idx <= r_idx + TCW'(1);
            if (i_cmd.apply) begin
                r_st <= ent.nxt;
                if (ent.eps) r_eps_cnt <= r_eps_cnt + 10'd1;
                r_sp <= (cnt_eff == 2'd0) ? base : r_sp;
            end
            if (i_cmd.push_second) r_sp <= r_sp + SPW'(1);
        end
    end

    always_comb begin
        o_stat.op        = r_op;
        o_stat.halted    = r_halted;
        o_stat.sp_zero   = (r_sp == '0);
        o_stat.sp_full   = ({{(32-SPW){1'b0}}, r_sp} >= STACK_DEPTH);
        o_stat.scan_done = (scan_pos >= {25'd0, r_entry_count}) || (scan_pos >= TABLE_DEPTH);
        o_stat.match     = (ent.st == r_st) && (ent.top == r_top)
                           && (ent.eps || ((r_op == pda_pkg::OpSym) && (ent.sym == r_sym)));
        o_stat.ent_eps   = ent.eps;
        o_stat.eps_over  = (r_eps_cnt >= r_eps_limit);
        o_stat.ovf       = (push_end > STACK_DEPTH);
        o_stat.cnt_two   = (cnt_eff == 2'd2);
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_accepted      = r_acc;
    assign o_current_state = r_st;
    assign o_stack_level   = r_sp;
endmodule

// ===== rtl/pushdown_automaton_recognizer_top.sv =====
// Top level of the deterministic pushdown automaton recognizer.
`timescale 1ns / 1ps
// A word is taken when start is high while busy is low; its one result word appears
// on o_status, o_accepted, o_current_state and o_stack_level for exactly one cycle with
// o_done high, and the receiver cannot stall it. Load, start, push and undefined words
// finish in the decode state. A symbol or end word passes the decode state, then, per
// move, fetches the stack top, scans table entries (one table RAM read and compare
// per entry, in entry order up to entry_count or the table depth) and applies the
// entry; epsilon moves repeat this. The table and stack are RAMs with no reset;
// configuration writes are taken any cycle (o_cfg_ready is tied high) but are meant
// for when the block is idle.
module pushdown_automaton_recognizer_top #(
    parameter int TABLE_DEPTH = pda_pkg::TableDepthDefault,
    parameter int STACK_DEPTH = pda_pkg::StackDepthDefault,
    localparam int SPW = $clog2(STACK_DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic [2:0]     i_op,
    input  logic [5:0]     i_entry_index,
    input  logic [3:0]     i_entry_state,
    input  logic           i_entry_on_epsilon,
    input  logic [7:0]     i_entry_symbol,
    input  logic [7:0]     i_entry_top,
    input  logic [3:0]     i_entry_next_state,
    input  logic [1:0]     i_entry_push_count,
    input  logic [7:0]     i_entry_push_first,
    input  logic [7:0]     i_entry_push_second,
    input  logic [7:0]     i_symbol,
    output logic           o_done,
    output logic [1:0]     o_status,
    output logic           o_accepted,
    output logic [3:0]     o_current_state,
    output logic [SPW-1:0] o_stack_level
);
    pda_pkg::t_cmd   cmd;
    pda_pkg::t_stat  stat;
    pda_pkg::t_entry entry;

    assign o_cfg_ready = 1'b1;

    // pack the loaded entry fields
    assign entry.st  = i_entry_state;
    assign entry.eps = i_entry_on_epsilon;
    assign entry.sym = i_entry_symbol;
    assign entry.top = i_entry_top;
    assign entry.nxt = i_entry_next_state;
    assign entry.cnt = i_entry_push_count;
    assign entry.p1  = i_entry_push_first;
    assign entry.p2  = i_entry_push_second;

    pda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pda_dp #(.TABLE_DEPTH(TABLE_DEPTH), .STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_entry_index   (i_entry_index),
        .i_entry         (entry),
        .i_symbol        (i_symbol),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_accepted      (o_accepted),
        .o_current_state (o_current_state),
        .o_stack_level   (o_stack_level)
    );
endmodule

// ===== dv/tb_pushdown_automaton_recognizer_top.sv =====
// Testbench for the pushdown automaton recognizer: directed runs, random runs, self-checking.
`timescale 1ns / 1ps
module tb_pushdown_automaton_recognizer_top;

    localparam int TBL_N = 64;
    localparam int STK_N = 256;
    localparam longint CYCLE_LIMIT = 6000000;

    // alphabet used to build tables that actually get matched
    localparam logic [7:0] SymBar = "|";
    localparam logic [7:0] SymQ   = "q";
    localparam logic [7:0] SymA   = "a";
    localparam logic [7:0] SymB   = "b";
    localparam logic [7:0] StkZ   = "Z";
    localparam logic [7:0] StkX   = "X";
    localparam logic [2:0] OpBad  = 3'd7;

    typedef struct {
        logic [1:0] status;
        logic       accepted;
        logic [3:0] state;
        logic [8:0] level;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic [2:0]  i_op;
    logic [5:0]  i_entry_index;
    pda_pkg::t_entry drv_entry;
    logic [7:0]  i_symbol;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_accepted;
    logic [3:0]  o_current_state;
    logic [8:0]  o_stack_level;

    pushdown_automaton_recognizer_top DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_op                (i_op),
        .i_entry_index       (i_entry_index),
        .i_entry_state       (drv_entry.st),
        .i_entry_on_epsilon  (drv_entry.eps),
        .i_entry_symbol      (drv_entry.sym),
        .i_entry_top         (drv_entry.top),
        .i_entry_next_state  (drv_entry.nxt),
        .i_entry_push_count  (drv_entry.cnt),
        .i_entry_push_first  (drv_entry.p1),
        .i_entry_push_second (drv_entry.p2),
        .i_symbol            (i_symbol),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_accepted          (o_accepted),
        .o_current_state     (o_current_state),
        .o_stack_level       (o_stack_level)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // ---------------------------------------------------------------
    // Automaton predictor: shadow copy of table, stack and registers
    // ---------------------------------------------------------------
    pda_pkg::t_entry pda_table [TBL_N];
    logic [7:0]  pda_stack [STK_N];
    int unsigned pda_sp;
    logic [3:0]  pda_state;
    bit          pda_halted;

    logic [3:0]  reg_start_state;
    logic [7:0]  reg_init_symbol;
    logic [15:0] reg_accept_mask;
    logic        reg_accept_empty;
    logic [6:0]  reg_entry_count;
    logic [9:0]  reg_eps_limit;

    t_result expected_results[$];

    int  gap_pct;
    int  words_sent;
    int  results_seen;
    int  accepts_seen;
    int  errors;
    longint cycles;

    // first matching entry for the current state and stack top, or -1
    function automatic int find_move(logic [7:0] sym, bit eps_only);
        int n;
        logic [7:0] top;
        n = (reg_entry_count > TBL_N) ? TBL_N : reg_entry_count;
        if (pda_sp == 0) return -1;
        top = pda_stack[pda_sp - 1];
        for (int i = 0; i < n; i++) begin
            if (pda_table[i].st != pda_state || pda_table[i].top != top) continue;
            if (pda_table[i].eps || (!eps_only && pda_table[i].sym == sym)) return i;
        end
        return -1;
    endfunction

    function automatic logic [1:0] apply_move(pda_pkg::t_entry e);
        int unsigned c;
        int unsigned base;
        c = (e.cnt > 2) ? 2 : e.cnt;
        base = pda_sp - 1;
        if (base + c > STK_N) return pda_pkg::StOverflow;
        pda_state = e.nxt;
        pda_sp = base;
        if (c == 2) begin
            pda_stack[pda_sp] = e.p2;
            pda_sp++;
        end
        if (c >= 1) begin
            pda_stack[pda_sp] = e.p1;
            pda_sp++;
        end
        return pda_pkg::StOk;
    endfunction

    // chains epsilon moves until a consuming move, a dead end or an error
    function automatic logic [1:0] run_moves(logic [7:0] sym, bit eps_only);
        int unsigned eps_moves;
        int k;
        pda_pkg::t_entry e;
        logic [1:0] s;
        eps_moves = 0;
        forever begin
            k = find_move(sym, eps_only);
            if (k < 0) return eps_only ? pda_pkg::StOk : pda_pkg::StStuck;
            e = pda_table[k];
            if (e.eps) begin
                if (eps_moves >= reg_eps_limit) return pda_pkg::StEps;
                eps_moves++;
            end
            s = apply_move(e);
            if (s != pda_pkg::StOk) return s;
            if (!e.eps) return pda_pkg::StOk;
        end
    endfunction

    function automatic t_result predict_word(logic [2:0] op, logic [5:0] idx,
                                             pda_pkg::t_entry e, logic [7:0] sym);
        t_result r;
        r.status   = pda_pkg::StOk;
        r.accepted = 1'b0;
        case (op)
            pda_pkg::OpLoad: pda_table[idx] = e;
            pda_pkg::OpStart: begin
                pda_state    = reg_start_state;
                pda_stack[0] = reg_init_symbol;
                pda_sp       = 1;
                pda_halted   = 1'b0;
            end
            pda_pkg::OpPush, pda_pkg::OpSym, pda_pkg::OpEnd: begin
                if (pda_halted) begin
                    r.status = pda_pkg::StStuck;
                end else if (op == pda_pkg::OpPush) begin
                    if (pda_sp >= STK_N) r.status = pda_pkg::StOverflow;
                    else begin
                        pda_stack[pda_sp] = sym;
                        pda_sp++;
                    end
                end else if (op == pda_pkg::OpSym) begin
                    r.status = run_moves(sym, 1'b0);
                end else begin
                    r.status = run_moves(8'd0, 1'b1);
                    if (r.status == pda_pkg::StOk) begin
                        if (reg_accept_empty) r.accepted = (pda_sp == 0);
                        else r.accepted = reg_accept_mask[pda_state];
                    end
                end
                if (r.status != pda_pkg::StOk) pda_halted = 1'b1;
            end
            default: ;
        endcase
        r.state = pda_state;
        r.level = pda_sp[8:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checker: every strobe must match the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word status=%0d acc=%0b state=%0d level=%0d",
                         $time, o_status, o_accepted, o_current_state, o_stack_level);
            end else begin
                t_result w;
                w = expected_results.pop_front();
                if (w.accepted) accepts_seen++;
                if (o_status !== w.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, w.status, o_status);
                end
                if (o_accepted !== w.accepted) begin
                    errors++;
                    $display("%0t: accepted expected %0b actual %0b",
                             $time, w.accepted, o_accepted);
                end
                if (o_current_state !== w.state) begin
                    errors++;
                    $display("%0t: state expected %0d actual %0d",
                             $time, w.state, o_current_state);
                end
                if (o_stack_level !== w.level) begin
                    errors++;
                    $display("%0t: stack level expected %0d actual %0d",
                             $time, w.level, o_stack_level);
                end
            end
        end
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, expected_results.size());
            $display("[pushdown_automaton_recognizer_top] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers. All driving happens on the falling edge.
    // ---------------------------------------------------------------
    function automatic pda_pkg::t_entry mk(logic [3:0] st, logic eps, logic [7:0] sym,
                                           logic [7:0] top, logic [3:0] nxt, logic [1:0] cnt,
                                           logic [7:0] p1, logic [7:0] p2);
        pda_pkg::t_entry e;
        e.st = st; e.eps = eps; e.sym = sym; e.top = top;
        e.nxt = nxt; e.cnt = cnt; e.p1 = p1; e.p2 = p2;
        return e;
    endfunction

    // caller is at a falling edge; returns at a falling edge with start still high unless a random gap dropped it
    task automatic send_word(logic [2:0] op, logic [5:0] idx, pda_pkg::t_entry e,
                             logic [7:0] sym);
        start         = 1'b1;
        i_op          = op;
        i_entry_index = idx;
        drv_entry     = e;
        i_symbol      = sym;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        expected_results.push_back(predict_word(op, idx, e, sym));
        words_sent++;
        @(negedge i_clk);
        if ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic send_op(logic [2:0] op, logic [7:0] sym);
        send_word(op, 6'd0, '0, sym);
    endtask

    task automatic load_entry(int idx, pda_pkg::t_entry e);
        send_word(pda_pkg::OpLoad, idx[5:0], e, 8'd0);
    endtask

    // let every word finish, then give the block time to settle
    task automatic drain;
        start = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            pda_pkg::CfgStartState:  reg_start_state  = val[3:0];
            pda_pkg::CfgInitSymbol:  reg_init_symbol  = val[7:0];
            pda_pkg::CfgAcceptMask:  reg_accept_mask  = val;
            pda_pkg::CfgAcceptEmpty: reg_accept_empty = val[0];
            pda_pkg::CfgEntryCount:  reg_entry_count  = val[6:0];
            pda_pkg::CfgEpsLimit:    reg_eps_limit    = val[9:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_sym();
        case ($urandom_range(3))
            0: return SymBar;
            1: return SymQ;
            2: return SymA;
            default: return StkZ;
        endcase
    endfunction

    function automatic pda_pkg::t_entry rand_entry(int states);
        pda_pkg::t_entry e;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(9) == 0) begin
            e = pda_pkg::t_entry'(raw[$bits(pda_pkg::t_entry)-1:0]);
        end else begin
            e = mk(4'($urandom_range(states - 1)), ($urandom_range(99) < 15), pick_sym(),
                   pick_sym(), 4'($urandom_range(states - 1)), 2'($urandom_range(3)),
                   pick_sym(), pick_sym());
        end
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // a^n b^n: push X per a, pop per b, epsilon to the accepting state on Z
    task automatic test_balanced_strings;
        load_entry(0, mk(4'd0, 1'b0, SymA, StkZ, 4'd0, 2'd2, StkX, StkZ));
        load_entry(1, mk(4'd0, 1'b0, SymA, StkX, 4'd0, 2'd2, StkX, StkX));
        load_entry(2, mk(4'd0, 1'b0, SymB, StkX, 4'd1, 2'd0, 8'd0, 8'd0));
        load_entry(3, mk(4'd1, 1'b0, SymB, StkX, 4'd1, 2'd0, 8'd0, 8'd0));
        load_entry(4, mk(4'd1, 1'b1, 8'd0, StkZ, 4'd2, 2'd1, StkZ, 8'd0));
        load_entry(5, mk(4'd2, 1'b1, 8'd0, StkZ, 4'd3, 2'd0, 8'd0, 8'd0));
        write_reg(pda_pkg::CfgInitSymbol, {8'd0, StkZ});
        write_reg(pda_pkg::CfgStartState, 16'd0);
        write_reg(pda_pkg::CfgAcceptMask, 16'h0004);
        write_reg(pda_pkg::CfgAcceptEmpty, 16'd0);
        write_reg(pda_pkg::CfgEntryCount, 16'd5);
        write_reg(pda_pkg::CfgEpsLimit, 16'd4);
        send_op(pda_pkg::OpStart, 8'd0);
        send_op(pda_pkg::OpSym, SymA);
        send_op(pda_pkg::OpSym, SymA);
        send_op(pda_pkg::OpSym, SymB);
        send_op(pda_pkg::OpSym, SymB);
        send_op(pda_pkg::OpEnd, 8'd0);
        send_op(pda_pkg::OpEnd, 8'd0);       // end does not halt
        send_op(pda_pkg::OpStart, 8'd0);
        send_op(pda_pkg::OpSym, SymB);       // no move: stuck
        send_op(pda_pkg::OpPush, SymA);      // halted run answers stuck
        send_op(pda_pkg::OpEnd, 8'd0);
        send_op(OpBad, 8'hFF);               // undefined op is ignored
        // empty-stack acceptance: state 2 pops Z
        write_reg(pda_pkg::CfgEntryCount, 16'd6);
        write_reg(pda_pkg::CfgAcceptEmpty, 16'd1);
        send_op(pda_pkg::OpStart, 8'd0);
        send_op(pda_pkg::OpSym, SymA);
        send_op(pda_pkg::OpSym, SymB);
        send_op(pda_pkg::OpEnd, 8'd0);
        send_op(pda_pkg::OpSym, SymA);       // empty stack matches nothing
    endtask

    // epsilon loop that replaces Z by Z Z forever runs into the limit
    task automatic test_epsilon_limit;
        load_entry(0, mk(4'd0, 1'b1, 8'd0, StkZ, 4'd0, 2'd3, StkZ, StkZ));
        load_entry(1, mk(4'd0, 1'b1, 8'd0, StkZ, 4'd5, 2'd1, StkZ, 8'd0));
        write_reg(pda_pkg::CfgEntryCount, 16'd2);
        write_reg(pda_pkg::CfgEpsLimit, 16'd1);
        send_op(pda_pkg::OpStart, 8'd0);
        send_op(pda_pkg::OpEnd, 8'd0);       // first move grows stack, second hits the limit
        // limit at maximum: the growing loop overflows the stack instead
        write_reg(pda_pkg::CfgEntryCount, 16'd1);
        write_reg(pda_pkg::CfgEpsLimit, 16'd1023);
        send_op(pda_pkg::OpStart, 8'd0);
        send_op(pda_pkg::OpSym, SymA);
        send_op(pda_pkg::OpSym, SymA);
    endtask

    // fill the stack by pushes, then one more push overflows
    task automatic test_full_stack;
        write_reg(pda_pkg::CfgEntryCount, 16'd0);
        send_op(pda_pkg::OpStart, 8'd0);
        for (int i = 0; i < STK_N - 1; i++) send_op(pda_pkg::OpPush, 8'($urandom));
        send_op(pda_pkg::OpPush, 8'hFF);
        send_op(pda_pkg::OpPush, 8'h00);
    endtask

    // register extremes; the entry count saturates at the table size
    task automatic test_register_extremes;
        load_entry(63, mk(4'd15, 1'b1, 8'hFF, 8'hFF, 4'd15, 2'd0, 8'hFF, 8'hFF));
        write_reg(pda_pkg::CfgStartState, 16'd15);
        write_reg(pda_pkg::CfgInitSymbol, 16'hFF);
        write_reg(pda_pkg::CfgAcceptMask, 16'hFFFF);
        write_reg(pda_pkg::CfgAcceptEmpty, 16'd0);
        write_reg(pda_pkg::CfgEntryCount, 16'd127);
        write_reg(pda_pkg::CfgEpsLimit, 16'd1023);
        send_op(pda_pkg::OpStart, 8'd0);
        send_op(pda_pkg::OpEnd, 8'd0);
        write_reg(pda_pkg::CfgEntryCount, 16'd64);
        write_reg(pda_pkg::CfgAcceptEmpty, 16'd1);
        send_op(pda_pkg::OpStart, 8'd0);
        send_op(pda_pkg::OpEnd, 8'd0);
    endtask

    // random tables over a small alphabet; mostly well-formed runs, some noise
    task automatic test_random_runs(int target);
        int sent0;
        int states;
        int len;
        logic [63:0] raw;
        sent0 = words_sent;
        for (int phase = 0; words_sent - sent0 < target; phase++) begin
            gap_pct = (phase % 9 < 3) ? 14 : (phase % 9 < 6) ? 52 : 0;
            states = $urandom_range(1, 4);
            for (int i = 0; i < TBL_N; i++) load_entry(i, rand_entry(states));
            write_reg(pda_pkg::CfgStartState, 16'($urandom_range(states - 1)));
            write_reg(pda_pkg::CfgInitSymbol, {8'd0, pick_sym()});
            write_reg(pda_pkg::CfgAcceptMask, 16'($urandom));
            write_reg(pda_pkg::CfgAcceptEmpty, 16'($urandom_range(1)));
            write_reg(pda_pkg::CfgEntryCount, 16'(($urandom_range(7) == 0)
                                                  ? $urandom_range(65, 127)
                                                  : $urandom_range(1, 24)));
            write_reg(pda_pkg::CfgEpsLimit, 16'($urandom_range(1, 12)));
            repeat (6) begin
                send_op(pda_pkg::OpStart, 8'd0);
                repeat ($urandom_range(2)) send_op(pda_pkg::OpPush, pick_sym());
                len = $urandom_range(10);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(99) < 8) begin
                        raw = {$urandom, $urandom};
                        send_word(3'($urandom_range(7)), 6'($urandom),
                                  pda_pkg::t_entry'(raw[$bits(pda_pkg::t_entry)-1:0]),
                                  8'($urandom));
                    end else begin
                        send_op(pda_pkg::OpSym, pick_sym());
                    end
                end
                send_op(pda_pkg::OpEnd, 8'd0);
            end
        end
    endtask

    initial begin
        start       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_op        = '0;
        i_entry_index = '0;
        drv_entry   = '0;
        i_symbol    = '0;
        gap_pct     = 14;
        words_sent  = 0;
        results_seen = 0;
        accepts_seen = 0;
        errors      = 0;
        cycles      = 0;
        pda_sp      = 0;
        pda_state   = '0;
        pda_halted  = 1'b0;
        reg_start_state  = pda_pkg::StartStateReset;
        reg_init_symbol  = pda_pkg::InitSymbolReset;
        reg_accept_mask  = '0;
        reg_accept_empty = 1'b0;
        reg_entry_count  = '0;
        reg_eps_limit    = pda_pkg::EpsLimitReset;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // every slot is written before any search can reach it
        for (int i = 0; i < TBL_N; i++) load_entry(i, rand_entry(16));
        test_balanced_strings();
        test_epsilon_limit();
        test_register_extremes();
        test_full_stack();
        test_random_runs(400);

        drain();
        repeat (200) @(negedge i_clk);
        $display("Covered %0d words (%0d results, %0d accepted strings) over directed and",
                 words_sent, results_seen, accepts_seen);
        $display("random tables, with register extremes, overflow and epsilon-limit runs.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[pushdown_automaton_recognizer_top] OK");
        end else begin
            $display("[pushdown_automaton_recognizer_top] ERROR");
        end
        $finish;
    end

endmodule
